@@ hdl/sgre_pkg.sv @@
// Package for the scaled glyph rectangle emitter: font table, character
// codes, result status codes and the glyph ROM request type.
// No dependencies; imported by every module of the block.
package sgre_pkg;

   // Number of glyphs the ROM serves; indices at or beyond read as not found
   localparam int GLYPH_COUNT = 19;
   localparam int GLYPH_ROWS  = 8;
   localparam int ROM_DEPTH   = GLYPH_COUNT * GLYPH_ROWS;
   localparam int ROM_ADDR_W  = $clog2(ROM_DEPTH);

   // Glyph index covers letters and digits (0..35)
   localparam int GLYPH_IDX_W = 6;
   localparam int ROW_W       = 3;

   // Font table addressing: 18 defined glyphs of 8 rows
   localparam int FONT_ENTRIES = 144;
   localparam int FONT_IDX_W   = 8;
   localparam int FONT_ADDR_W  = GLYPH_IDX_W + ROW_W;

   // Character codes
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_Z = 8'h5A;
   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_9 = 8'h39;
   localparam logic [GLYPH_IDX_W-1:0] DIGIT_BASE = 6'd26;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_RECT      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_EMPTY     = 2'd2
   } status_type;

   // Read request to the glyph ROM
   typedef struct packed {
      logic                  en;
      logic [ROM_ADDR_W-1:0] addr;
   } rom_req_type;

   // Font rows, glyph after glyph, top row first, leftmost pixel in the MSB
   localparam logic [7:0] FONT_ROWS [0:FONT_ENTRIES-1] = '{
      8'h30, 8'h78, 8'hCC, 8'hCC, 8'hFC, 8'hCC, 8'hCC, 8'h00,
      8'hFC, 8'h66, 8'h66, 8'h7C, 8'h66, 8'h66, 8'hFC, 8'h00,
      8'h3C, 8'h66, 8'hC0, 8'hC0, 8'hC0, 8'h66, 8'h3C, 8'h00,
      8'hF8, 8'h6C, 8'h66, 8'h66, 8'h66, 8'h6C, 8'hF8, 8'h00,
      8'hFE, 8'h62, 8'h68, 8'h78, 8'h68, 8'h62, 8'hFE, 8'h00,
      8'hFE, 8'h62, 8'h68, 8'h78, 8'h68, 8'h60, 8'hF0, 8'h00,
      8'h3C, 8'h66, 8'hC0, 8'hC0, 8'hCE, 8'h66, 8'h3E, 8'h00,
      8'hCC, 8'hCC, 8'hCC, 8'hFC, 8'hCC, 8'hCC, 8'hCC, 8'h00,
      8'h78, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h78, 8'h00,
      8'h1E, 8'h0C, 8'h0C, 8'h0C, 8'hCC, 8'hCC, 8'h78, 8'h00,
      8'hE6, 8'h66, 8'h6C, 8'h78, 8'h6C, 8'h66, 8'hE6, 8'h00,
      8'hF0, 8'h60, 8'h60, 8'h60, 8'h62, 8'h66, 8'hFE, 8'h00,
      8'hC6, 8'hEE, 8'hFE, 8'hFE, 8'hD6, 8'hC6, 8'hC6, 8'h00,
      8'hC6, 8'hE6, 8'hF6, 8'hDE, 8'hCE, 8'hC6, 8'hC6, 8'h00,
      8'h38, 8'h6C, 8'hC6, 8'hC6, 8'hC6, 8'h6C, 8'h38, 8'h00,
      8'hFC, 8'h66, 8'h66, 8'h7C, 8'h60, 8'h60, 8'hF0, 8'h00,
      8'h78, 8'hCC, 8'hCC, 8'hCC, 8'hDC, 8'h78, 8'h1C, 8'h00,
      8'hFC, 8'h66, 8'h66, 8'h7C, 8'h6C, 8'h66, 8'hE6, 8'h00
   };

   // Look up one font row; glyphs past the defined set are blank
   function automatic logic [7:0] font_row(input logic [FONT_ADDR_W-1:0] addr);
      logic [7:0] row_bits;
      row_bits = 8'h00;
      if (addr < FONT_ADDR_W'(FONT_ENTRIES)) begin
         row_bits = FONT_ROWS[addr[FONT_IDX_W-1:0]];
      end
      return row_bits;
   endfunction

endpackage

@@ hdl/sgre_glyph_rom.sv @@
// Glyph ROM: one font row per address, registered read data.
// Depends on sgre_pkg for the font table and the request type.
module sgre_glyph_rom import sgre_pkg::*; (
   input  logic        clock,
   input  rom_req_type rom_req,
   output logic [7:0]  rd_data
);

   logic [7:0] rd_data_ff;

   // Read on request; hold the last row otherwise
   always_ff @(posedge clock) begin
      if (rom_req.en) begin
         rd_data_ff <= font_row(FONT_ADDR_W'(rom_req.addr));
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/scaled_glyph_rectangle_emitter.sv @@
// Scaled glyph rectangle emitter, top level.
// Depends on sgre_pkg and sgre_glyph_rom.
//
// Usage: each req transaction carries one character (tdata: char_code,
// start_x, start_y, scale from the lowest byte up; tuser: new_string).
// For each set pixel of the character's 8x8 glyph the block sends one rsp
// transaction with a filled square (tdata: left, top, right, bottom from the
// lowest byte up; tuser: status), rows top to bottom, leftmost pixel first.
// tlast marks the final result of a character. A character that is not a
// known letter or digit gives one not-found result; a blank glyph gives one
// empty result. The pen x advances by 8 * scale after every character.
// Sequence: a character is taken in ST_IDLE, then the glyph is scanned one
// pixel per cycle while the receiver does not stall (one ROM row read per 8
// pixels, overlapped with the scan), then ST_FLUSH closes the run; an unknown
// character goes straight to ST_FLUSH. Each result is held back one set pixel
// so that the last can be marked.
// Reset clears the pen x to zero and drops any result in flight.
// When the receiver stalls, the scan holds in place; no result is lost.
module scaled_glyph_rectangle_emitter import sgre_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // char_code, start_x, start_y, scale
   input  logic        req_tuser,   // new_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // rect_left, rect_top, rect_right, rect_bottom
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast    // last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   state_type                state_ff, state_in;
   logic [7:0]               pen_x_ff, pen_x_in;
   logic [7:0]               base_x_ff, base_x_in;
   logic [7:0]               col_x_ff, col_x_in;
   logic [7:0]               row_y_ff, row_y_in;
   logic [7:0]               scale_ff, scale_in;
   logic [GLYPH_IDX_W-1:0]   glyph_ff, glyph_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [ROW_W-1:0]         col_ff, col_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [7:0]               pend_left_ff, pend_left_in;
   logic [7:0]               pend_top_ff, pend_top_in;
   status_type               flush_status_ff, flush_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [7:0]               rsp_left_ff, rsp_left_in;
   logic [7:0]               rsp_top_ff, rsp_top_in;
   logic [7:0]               rsp_right_ff, rsp_right_in;
   logic [7:0]               rsp_bottom_ff, rsp_bottom_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [7:0]               char_code;
   logic [7:0]               start_x;
   logic [7:0]               start_y;
   logic [7:0]               scale;
   logic                     is_letter;
   logic                     is_digit;
   logic [GLYPH_IDX_W-1:0]   dec_idx;
   logic                     dec_found;
   logic [7:0]               start_pen;
   logic                     out_free;
   logic                     pixel;
   rom_req_type              rom_req;
   logic [7:0]               rom_data;

   sgre_glyph_rom u_rom (
      .clock   (clock),
      .rom_req (rom_req),
      .rd_data (rom_data)
   );

   // Unpack the request transaction
   assign char_code = req_tdata[7:0];
   assign start_x   = req_tdata[15:8];
   assign start_y   = req_tdata[23:16];
   assign scale     = req_tdata[31:24];

   // Map letters and digits to glyph indices
   assign is_letter = (char_code >= CHAR_A) && (char_code <= CHAR_Z);
   assign is_digit  = (char_code >= CHAR_0) && (char_code <= CHAR_9);
   assign dec_idx   = is_letter ? GLYPH_IDX_W'(char_code - CHAR_A)
                                : GLYPH_IDX_W'(char_code - CHAR_0) + DIGIT_BASE;
   assign dec_found = (is_letter || is_digit) &&
                      (dec_idx < GLYPH_IDX_W'(GLYPH_COUNT));
   assign start_pen = req_tuser ? start_x : pen_x_ff;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pixel     = rom_data[3'd7 - col_ff];

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      pen_x_in        = pen_x_ff;
      base_x_in       = base_x_ff;
      col_x_in        = col_x_ff;
      row_y_in        = row_y_ff;
      scale_in        = scale_ff;
      glyph_in        = glyph_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      pend_valid_in   = pend_valid_ff;
      pend_left_in    = pend_left_ff;
      pend_top_in     = pend_top_ff;
      flush_status_in = flush_status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_status_in   = rsp_status_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_top_in      = rsp_top_ff;
      rsp_right_in    = rsp_right_ff;
      rsp_bottom_in   = rsp_bottom_ff;
      rsp_last_in     = rsp_last_ff;
      rom_req         = '0;

      case (state_ff)
         ST_IDLE: begin
            // Take a character, set up the pen and, for a known glyph, start the first row read
            if (req_tvalid) begin
               base_x_in     = start_pen;
               col_x_in      = start_pen;
               row_y_in      = start_y;
               scale_in      = scale;
               pen_x_in      = start_pen + {scale[4:0], 3'b000};
               glyph_in      = dec_idx;
               row_in        = '0;
               col_in        = '0;
               pend_valid_in = 1'b0;
               if (dec_found) begin
                  rom_req.en      = 1'b1;
                  rom_req.addr    = ROM_ADDR_W'({dec_idx, {ROW_W{1'b0}}});
                  flush_status_in = STATUS_EMPTY;
                  state_in        = ST_SCAN;
               end else begin
                  flush_status_in = STATUS_NOT_FOUND;
                  state_in        = ST_FLUSH;
               end
            end
         end
         ST_SCAN: begin
            // Step one pixel; send the held square when a new one is found
            if (out_free) begin
               if (pixel) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_RECT;
                     rsp_left_in   = pend_left_ff;
                     rsp_top_in    = pend_top_ff;
                     rsp_right_in  = pend_left_ff + scale_ff - 8'd1;
                     rsp_bottom_in = pend_top_ff + scale_ff - 8'd1;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_left_in  = col_x_ff;
                  pend_top_in   = row_y_ff;
               end
               col_in   = col_ff + 3'd1;
               col_x_in = col_x_ff + scale_ff;
               // End of row: rewind x, step y, fetch the next row or, after the last, go to flush
               if (col_ff == 3'd7) begin
                  col_x_in = base_x_ff;
                  row_y_in = row_y_ff + scale_ff;
                  row_in   = row_ff + 3'd1;
                  if (row_ff == 3'd7) begin
                     state_in = ST_FLUSH;
                  end else begin
                     rom_req.en   = 1'b1;
                     rom_req.addr = ROM_ADDR_W'({glyph_ff, row_ff + 3'd1});
                  end
               end
            end
         end
         ST_FLUSH: begin
            // Close the run: the held square or a status-only result
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (pend_valid_ff) begin
                  rsp_status_in = STATUS_RECT;
                  rsp_left_in   = pend_left_ff;
                  rsp_top_in    = pend_top_ff;
                  rsp_right_in  = pend_left_ff + scale_ff - 8'd1;
                  rsp_bottom_in = pend_top_ff + scale_ff - 8'd1;
               end else begin
                  rsp_status_in = flush_status_ff;
                  rsp_left_in   = 8'd0;
                  rsp_top_in    = 8'd0;
                  rsp_right_in  = 8'd0;
                  rsp_bottom_in = 8'd0;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, pen and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pen_x_ff      <= 8'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pen_x_ff      <= pen_x_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      base_x_ff       <= base_x_in;
      col_x_ff        <= col_x_in;
      row_y_ff        <= row_y_in;
      scale_ff        <= scale_in;
      glyph_ff        <= glyph_in;
      row_ff          <= row_in;
      col_ff          <= col_in;
      pend_left_ff    <= pend_left_in;
      pend_top_ff     <= pend_top_in;
      flush_status_ff <= flush_status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_top_ff      <= rsp_top_in;
      rsp_right_ff    <= rsp_right_in;
      rsp_bottom_ff   <= rsp_bottom_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_bottom_ff, rsp_right_ff, rsp_top_ff, rsp_left_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ tb/tb_scaled_glyph_rectangle_emitter.sv @@
// Self-checking testbench for scaled_glyph_rectangle_emitter: drives characters on the
// req stream, predicts the rectangles of each glyph and checks every rsp transaction.
// Depends on sgre_pkg and the emitter RTL, which also needs sgre_glyph_rom.
module tb_scaled_glyph_rectangle_emitter import sgre_pkg::*; ();

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 12;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int QUIET_LIMIT     = 3000;
   localparam int DRAIN_CYCLES    = 80;
   localparam int MAX_REPORTS     = 20;
   localparam int DRAWN_GLYPHS    = 18;

   // Glyph bitmaps, top row in the upper byte, leftmost pixel in the MSB of a row
   localparam logic [63:0] GLYPH_BITMAPS [0:DRAWN_GLYPHS-1] = '{
      64'h3078CCCCFCCCCC00, 64'hFC66667C6666FC00, 64'h3C66C0C0C0663C00,
      64'hF86C6666666CF800, 64'hFE6268786862FE00, 64'hFE6268786860F000,
      64'h3C66C0C0CE663E00, 64'hCCCCCCFCCCCCCC00, 64'h7830303030307800,
      64'h1E0C0C0CCCCC7800, 64'hE6666C786C66E600, 64'hF06060606266FE00,
      64'hC6EEFEFED6C6C600, 64'hC6E6F6DECEC6C600, 64'h386CC6C6C66C3800,
      64'hFC66667C6060F000, 64'h78CCCCCCDC781C00, 64'hFC66667C6C66E600
   };

   localparam logic [15:0] STALL_PATTERN = 16'b1011_0011_1110_0100;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN
   } ready_mode_type;

   typedef struct packed {
      status_type status;
      logic [7:0] left;
      logic [7:0] top;
      logic [7:0] right;
      logic [7:0] bottom;
      logic       last;
   } glyph_rect_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // char_code, start_x, start_y, scale
   logic        req_tuser = 1'b0; // new_string
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // rect_left, rect_top, rect_right, rect_bottom
   logic [1:0]  rsp_tuser;        // status
   logic        rsp_tlast;        // last

   glyph_rect_type pending_rects[$];
   logic [7:0]     pen_x = 8'h00;
   int             mismatch_count = 0;
   int             quiet_cycles = 0;
   int             burst_left = 0;
   bit             gaps_on = 1'b1;
   bit             hold_off_request = 1'b0;
   ready_mode_type ready_mode = READY_ALWAYS;

   scaled_glyph_rectangle_emitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Work out the rectangles of one accepted character and advance the pen
   task automatic render_glyph(input logic [7:0] code, input logic fresh,
                               input logic [7:0] start_x, input logic [7:0] start_y,
                               input logic [7:0] scale);
      int             index;
      int             emitted;
      logic [63:0]    bitmap;
      logic [7:0]     row_bits;
      glyph_rect_type rect;
      index = -1;
      emitted = 0;
      bitmap = '0;
      if (fresh) begin
         pen_x = start_x;
      end
      if (code >= CHAR_A && code <= CHAR_Z) begin
         index = int'(code - CHAR_A);
      end else if (code >= CHAR_0 && code <= CHAR_9) begin
         index = int'(code - CHAR_0) + 26;
      end
      if (index < 0 || index >= GLYPH_COUNT) begin
         rect = '{STATUS_NOT_FOUND, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1};
         pending_rects.push_back(rect);
      end else begin
         if (index < DRAWN_GLYPHS) begin
            bitmap = GLYPH_BITMAPS[index];
         end
         for (int row = 0; row < 8; row++) begin
            row_bits = bitmap[63 - 8 * row -: 8];
            for (int col = 0; col < 8; col++) begin
               if (row_bits[7 - col]) begin
                  rect.status = STATUS_RECT;
                  rect.left   = pen_x + 8'(col) * scale;
                  rect.top    = start_y + 8'(row) * scale;
                  rect.right  = rect.left + scale - 8'd1;
                  rect.bottom = rect.top + scale - 8'd1;
                  rect.last   = 1'b0;
                  pending_rects.push_back(rect);
                  emitted++;
               end
            end
         end
         if (emitted == 0) begin
            rect = '{STATUS_EMPTY, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1};
            pending_rects.push_back(rect);
         end else begin
            pending_rects[$].last = 1'b1;
         end
      end
      pen_x = pen_x + {scale[4:0], 3'b000};
   endtask

   // Offer one character; idle between bursts when gaps are enabled
   task automatic send_char(input logic [7:0] code, input logic fresh,
                            input logic [7:0] start_x, input logic [7:0] start_y,
                            input logic [7:0] scale);
      int gap;
      @(negedge clock);
      if (gaps_on && burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 10);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {scale, start_y, start_x, code};
      req_tuser  <= fresh;
      do @(posedge clock); while (!req_tready);
      render_glyph(code, fresh, start_x, start_y, scale);
      burst_left--;
   endtask

   function automatic logic [7:0] pick_char();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return CHAR_A + 8'($urandom_range(0, DRAWN_GLYPHS - 1));
      if (roll < 83) return CHAR_A + 8'($urandom_range(DRAWN_GLYPHS, 25));
      if (roll < 91) return CHAR_0 + 8'($urandom_range(0, 9));
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_scale();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 8'($urandom_range(1, 12));
      if (roll < 75) return 8'($urandom_range(0, 40));
      if (roll < 85) return 8'd0;
      if (roll < 92) return 8'd255;
      return 8'($urandom);
   endfunction

   // Field extremes, not-found and empty glyphs, zero scale and wrap-around
   task automatic test_directed();
      ready_mode = READY_ALWAYS;
      gaps_on = 1'b0;
      send_char(CHAR_A, 1'b1, 8'h00, 8'h00, 8'd1);
      send_char(CHAR_A + 8'd1, 1'b0, 8'hFF, 8'h00, 8'd1);
      // blank glyph past the drawn set
      send_char(CHAR_A + 8'd18, 1'b0, 8'h00, 8'h10, 8'd2);
      // letters at or beyond the glyph count
      send_char(CHAR_A + 8'd19, 1'b0, 8'h00, 8'h10, 8'd3);
      send_char(CHAR_Z, 1'b0, 8'h00, 8'h10, 8'd1);
      // digits map past the glyph count
      send_char(CHAR_0, 1'b1, 8'h20, 8'h20, 8'd1);
      send_char(CHAR_9, 1'b0, 8'h20, 8'h20, 8'd1);
      // neighbors of the letter and digit ranges, and byte extremes
      send_char(CHAR_A - 8'd1, 1'b0, 8'h00, 8'h00, 8'd1);
      send_char(CHAR_Z + 8'd1, 1'b0, 8'h00, 8'h00, 8'd1);
      send_char(CHAR_0 - 8'd1, 1'b0, 8'h00, 8'h00, 8'd1);
      send_char(CHAR_9 + 8'd1, 1'b0, 8'h00, 8'h00, 8'd1);
      send_char(8'h00, 1'b0, 8'h00, 8'h00, 8'd1);
      send_char(8'hFF, 1'b0, 8'h00, 8'h00, 8'd1);
      send_char(CHAR_A + 8'd32, 1'b0, 8'h00, 8'h00, 8'd1);
      // zero scale wraps right and bottom below left and top
      send_char(CHAR_A + 8'd12, 1'b1, 8'h40, 8'h40, 8'd0);
      // position and scale at their top values, then mixed positions and scales
      send_char(CHAR_A + 8'd17, 1'b1, 8'hFF, 8'hFF, 8'd255);
      send_char(CHAR_A + 8'd16, 1'b0, 8'hA5, 8'h5A, 8'd37);
      send_char(CHAR_A + 8'd7, 1'b0, 8'h00, 8'hF0, 8'd128);
      send_char(CHAR_A + 8'd22, 1'b1, 8'hFF, 8'h00, 8'd255);
      send_char(CHAR_A + 8'd8, 1'b0, 8'h00, 8'h00, 8'd1);
   endtask

   // Strings: a fresh first character, then the pen carries across the rest
   task automatic test_string_runs(input int item_goal);
      int sent;
      int length;
      logic [7:0] start_y;
      logic [7:0] scale;
      sent = 0;
      while (sent < item_goal) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         gaps_on = ($urandom_range(0, 3) != 0);
         length = $urandom_range(1, 8);
         start_y = 8'($urandom);
         scale = pick_scale();
         for (int k = 0; k < length; k++) begin
            if ($urandom_range(0, 5) == 0) begin
               scale = pick_scale();
            end
            send_char(pick_char(), k == 0, 8'($urandom), start_y, scale);
            sent++;
         end
      end
   endtask

   // Hold the receiver off while characters keep coming so the input stalls
   task automatic test_input_stall();
      ready_mode = READY_ALWAYS;
      gaps_on = 1'b0;
      hold_off_request = 1'b1;
      for (int k = 0; k < 12; k++) begin
         send_char(CHAR_A + 8'($urandom_range(0, DRAWN_GLYPHS - 1)), k == 0,
                   8'($urandom), 8'($urandom), pick_scale());
      end
   endtask

   // Unstructured characters with every field random
   task automatic test_noise(input int item_goal);
      ready_mode = READY_RANDOM;
      gaps_on = 1'b1;
      for (int k = 0; k < item_goal; k++) begin
         send_char(8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   // Receiver: long hold-off on request, otherwise stall as the mode says
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end
         phase = (phase + 1) % 16;
         case (ready_mode)
            READY_ALWAYS: begin
               rsp_tready <= 1'b1;
            end
            READY_RANDOM: begin
               rsp_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_tready <= STALL_PATTERN[phase];
            end
         endcase
      end
   end

   // Compare each result transaction with the oldest pending rectangle
   always @(posedge clock) begin
      glyph_rect_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rects.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: unexpected result: expected none, actual status=%0d data=%h last=%b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
            end
         end else begin
            want = pending_rects.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[7:0] !== want.left ||
                rsp_tdata[15:8] !== want.top || rsp_tdata[23:16] !== want.right ||
                rsp_tdata[31:24] !== want.bottom || rsp_tlast !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch expected status=%0d l=%0d t=%0d r=%0d b=%0d last=%b",
                           $time, want.status, want.left, want.top, want.right,
                           want.bottom, want.last);
                  $display("%0t:          actual   status=%0d l=%0d t=%0d r=%0d b=%0d last=%b",
                           $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8],
                           rsp_tdata[23:16], rsp_tdata[31:24], rsp_tlast);
               end
            end
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, %0d results pending", $time, pending_rects.size());
         $display("FAIL scaled_glyph_rectangle_emitter");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_string_runs(300);
      test_input_stall();
      test_noise(130);
      @(negedge clock);
      req_tvalid <= 1'b0;
      ready_mode = READY_RANDOM;
      // drain, then allow a stray result time to show up
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS scaled_glyph_rectangle_emitter");
      end else begin
         $display("FAIL scaled_glyph_rectangle_emitter");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/sgre_pkg.sv
hdl/sgre_glyph_rom.sv
hdl/scaled_glyph_rectangle_emitter.sv
tb/tb_scaled_glyph_rectangle_emitter.sv
